// ===== hw/rtl/msb_pkg.sv =====
package msb_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS_INIT,
      ST_RUN_INIT,
      ST_READ,
      ST_MERGE,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } msb_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // accept one item into the store
      logic pass_init;   // start a merge pass at the first run
      logic run_init;    // set up bounds of the current run pair
      logic merge_step;  // write one merged element
      logic next_run;    // advance to the next run pair
      logic pass_end;    // swap banks, double the run width
      logic emit_init;   // point at the first sorted element
      logic emit_step;   // advance to the next sorted element
      logic finish;      // clear set state after the last result
   } msb_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic width_done;  // run width covers the whole set
      logic run_end;     // current element closes the run pair
      logic set_end;     // current run pair closes the pass
      logic emit_last;   // current result is the final one
   } msb_stat_type;

endpackage

// ===== hw/rtl/msb_ctrl.sv =====
module msb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_last,
   input  msb_pkg::msb_stat_type stat,
   output msb_pkg::msb_cmd_type  cmd,
   output logic                  busy,
   output logic                  rsp_valid
);
   import msb_pkg::*;

   msb_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_PASS_INIT;
               end
            end
         end
         ST_PASS_INIT: begin
            if (stat.width_done) begin
               cmd.emit_init = 1'b1;
               state_in      = ST_EMIT_RD;
            end else begin
               cmd.pass_init = 1'b1;
               state_in      = ST_RUN_INIT;
            end
         end
         ST_RUN_INIT: begin
            cmd.run_init = 1'b1;
            state_in     = ST_READ;
         end
         ST_READ: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge_step = 1'b1;
            if (!stat.run_end) begin
               state_in = ST_READ;
            end else if (stat.set_end) begin
               cmd.pass_end = 1'b1;
               state_in     = ST_PASS_INIT;
            end else begin
               cmd.next_run = 1'b1;
               state_in     = ST_RUN_INIT;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (stat.emit_last) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.emit_step = 1'b1;
               state_in      = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/msb_dpath.sv =====
module msb_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  msb_pkg::msb_cmd_type                cmd,
   output msb_pkg::msb_stat_type               stat,
   input  logic signed [msb_pkg::DATA_W-1:0]   req_value,
   output logic signed [msb_pkg::DATA_W-1:0]   rsp_sorted_value,
   output logic                                rsp_last_out,
   output logic                                rsp_overflow
);
   import msb_pkg::*;

   // two banks used ping-pong: a pass reads one and writes the other
   logic signed [DATA_W-1:0] item_store_ff [MAX_ITEMS];
   logic signed [DATA_W-1:0] scratch_ff    [MAX_ITEMS];

   logic signed [DATA_W-1:0] qa0_ff, qb0_ff, qa1_ff, qb1_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [CNT_W-1:0] width_ff, width_in;
   logic             src_ff, src_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] a_ff, a_in;
   logic [CNT_W-1:0] b_ff, b_in;
   logic [CNT_W-1:0] k_ff, k_in;

   logic [CNT_W:0]           mid_sum, hi_sum;
   logic [CNT_W-1:0]         mid_c, hi_c;
   logic signed [DATA_W-1:0] head_a, head_b, pick;
   logic                     take_a, room;
   logic                     wr0, wr1;
   logic [ADDR_W-1:0]        wr0_addr;
   logic signed [DATA_W-1:0] wr0_data;

   assign head_a = src_ff ? qa1_ff : qa0_ff;
   assign head_b = src_ff ? qb1_ff : qb0_ff;

   // stable merge: take from the left run unless the right head is smaller
   always_comb begin
      if (a_ff >= mid_ff) begin
         take_a = 1'b0;
      end else if (b_ff >= hi_ff) begin
         take_a = 1'b1;
      end else begin
         take_a = !(head_b < head_a);
      end
   end
   assign pick = take_a ? head_a : head_b;

   assign mid_sum = {1'b0, lo_ff} + {1'b0, width_ff};
   assign hi_sum  = {1'b0, lo_ff} + {width_ff, 1'b0};
   assign mid_c   = (mid_sum > {1'b0, count_ff}) ? count_ff : mid_sum[CNT_W-1:0];
   assign hi_c    = (hi_sum > {1'b0, count_ff}) ? count_ff : hi_sum[CNT_W-1:0];

   assign room = (count_ff < CNT_W'(MAX_ITEMS));

   assign stat.width_done = (width_ff >= count_ff);
   assign stat.run_end    = ((k_ff + CNT_W'(1)) == hi_ff);
   assign stat.set_end    = (hi_ff == count_ff);
   assign stat.emit_last  = ((a_ff + CNT_W'(1)) == count_ff);

   assign rsp_sorted_value = head_a;
   assign rsp_last_out     = stat.emit_last;
   assign rsp_overflow     = dropped_ff;

   // bank write ports
   assign wr0      = (cmd.load && room) || (cmd.merge_step && src_ff);
   assign wr1      = cmd.merge_step && !src_ff;
   assign wr0_addr = cmd.load ? count_ff[ADDR_W-1:0] : k_ff[ADDR_W-1:0];
   assign wr0_data = cmd.load ? req_value : pick;

   always_ff @(posedge clock) begin
      if (wr0) begin
         item_store_ff[wr0_addr] <= wr0_data;
      end
      qa0_ff <= item_store_ff[a_ff[ADDR_W-1:0]];
      qb0_ff <= item_store_ff[b_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr1) begin
         scratch_ff[k_ff[ADDR_W-1:0]] <= pick;
      end
      qa1_ff <= scratch_ff[a_ff[ADDR_W-1:0]];
      qb1_ff <= scratch_ff[b_ff[ADDR_W-1:0]];
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      width_in   = width_ff;
      src_in     = src_ff;
      lo_in      = lo_ff;
      mid_in     = mid_ff;
      hi_in      = hi_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      k_in       = k_ff;
      if (cmd.load) begin
         if (room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.pass_init) begin
         lo_in = '0;
      end
      if (cmd.run_init) begin
         mid_in = mid_c;
         hi_in  = hi_c;
         a_in   = lo_ff;
         b_in   = mid_c;
         k_in   = lo_ff;
      end
      if (cmd.merge_step) begin
         k_in = k_ff + CNT_W'(1);
         if (take_a) begin
            a_in = a_ff + CNT_W'(1);
         end else begin
            b_in = b_ff + CNT_W'(1);
         end
      end
      if (cmd.next_run) begin
         lo_in = hi_ff;
      end
      if (cmd.pass_end) begin
         src_in   = !src_ff;
         width_in = {width_ff[CNT_W-2:0], 1'b0};
      end
      if (cmd.emit_init) begin
         a_in = '0;
      end
      if (cmd.emit_step) begin
         a_in = a_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         count_in   = '0;
         dropped_in = 1'b0;
         width_in   = CNT_W'(1);
         src_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         width_ff   <= CNT_W'(1);
         src_ff     <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         width_ff   <= width_in;
         src_ff     <= src_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      mid_ff <= mid_in;
      hi_ff  <= hi_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
   end

endmodule

// ===== hw/rtl/merge_sort_block_unit.sv =====
// channel   ports                                    handshake
// -------   --------------------------------------   -------------------------------
// request   req_value, req_last                      taken when start high, busy low
// response  rsp_sorted_value, rsp_last_out,          one cycle under rsp_valid,
//           rsp_overflow                             no back-pressure
//
// loading accepts one item per cycle; busy stays low until an item with req_last
// sort: ceil(log2 n) passes, each a pass setup, then per run pair a run setup and per
//   element a bank read, then a compare and write; a last pass setup ends the sort
// emission: per result a registered bank read, then the strobe
// synchronous reset clears set count, overflow flag and controller; no receiver stall
module merge_sort_block_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic signed [msb_pkg::DATA_W-1:0]  req_value,
   input  logic                               req_last,
   output logic                               rsp_valid,
   output logic signed [msb_pkg::DATA_W-1:0]  rsp_sorted_value,
   output logic                               rsp_last_out,
   output logic                               rsp_overflow
);
   import msb_pkg::*;

   // command and status between controller and datapath
   msb_cmd_type  cmd;
   msb_stat_type stat;

   // controller: sequences load, merge passes and emission
   msb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_last  (req_last),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // datapath: ping-pong banks, run pointers, set count and overflow flag
   msb_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_value        (req_value),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   // a result only appears while the block is busy
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   // an item closing the set starts the sort
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last) |=> busy)
      else $error("sort did not start after last item");

   // the final result frees the block
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_out) |=> !busy)
      else $error("block still busy after final result");

   // results are spaced by the bank read cycle
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back result strobes");

endmodule

// ===== bench/sorted_set_monitor.sv =====
`timescale 1ns / 100ps

// watches both channels, predicts each sorted set and compares results
module sorted_set_monitor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic signed [msb_pkg::DATA_W-1:0]  req_value,
   input  logic                               req_last,
   input  logic                               rsp_valid,
   input  logic signed [msb_pkg::DATA_W-1:0]  rsp_sorted_value,
   input  logic                               rsp_last_out,
   input  logic                               rsp_overflow,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 sets_closed,
   output int                                 results_checked,
   output int                                 overflow_sets
);
   import msb_pkg::*;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      logic                     closes_set;
      logic                     overflow;
   } sorted_entry_type;

   sorted_entry_type         sorted_expect_q[$];
   logic signed [DATA_W-1:0] held_values[$];
   logic                     set_dropped;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count      = 0;
      pending         = 0;
      sets_closed     = 0;
      results_checked = 0;
      overflow_sets   = 0;
      set_dropped     = 1'b0;
   end

   always @(posedge clock) begin
      sorted_entry_type         want;
      logic signed [DATA_W-1:0] key;
      int                       j;
      if (reset) begin
         held_values.delete();
         sorted_expect_q.delete();
         set_dropped = 1'b0;
      end else begin
         // result side first: a result never belongs to the set closing now
         if (rsp_valid) begin
            if (sorted_expect_q.size() == 0) begin
               report_mismatch("unexpected result value", rsp_sorted_value, 0);
            end else begin
               want = sorted_expect_q.pop_front();
               if (rsp_sorted_value !== want.value)
                  report_mismatch("sorted_value", rsp_sorted_value, want.value);
               if (rsp_last_out !== want.closes_set)
                  report_mismatch("last_out", rsp_last_out, want.closes_set);
               if (rsp_overflow !== want.overflow)
                  report_mismatch("overflow", rsp_overflow, want.overflow);
               results_checked++;
            end
         end
         if (start && !busy) begin
            if (held_values.size() < MAX_ITEMS)
               held_values.push_back(req_value);
            else
               set_dropped = 1'b1;
            if (req_last) begin
               // stable insertion sort, signed ascending
               for (int i = 1; i < held_values.size(); i++) begin
                  key = held_values[i];
                  j   = i;
                  while (j > 0 && held_values[j-1] > key) begin
                     held_values[j] = held_values[j-1];
                     j--;
                  end
                  held_values[j] = key;
               end
               foreach (held_values[k]) begin
                  want.value      = held_values[k];
                  want.closes_set = (k == held_values.size() - 1);
                  want.overflow   = set_dropped;
                  sorted_expect_q.push_back(want);
               end
               if (set_dropped)
                  overflow_sets++;
               sets_closed++;
               held_values.delete();
               set_dropped = 1'b0;
            end
         end
      end
      pending = sorted_expect_q.size();
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

// stimulus and verdict for the merge sort block; all checking sits in the monitor
module testbench;
   import msb_pkg::*;

   localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   // a full set of 64 sorts well within this quiet limit
   localparam int QUIET_LIMIT = 20000;
   localparam int PHASE_ITEMS = 80;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [DATA_W-1:0] req_value;
   logic                     req_last;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_sorted_value;
   logic                     rsp_last_out;
   logic                     rsp_overflow;

   int fail_count;
   int pending;
   int sets_closed;
   int results_checked;
   int overflow_sets;

   int idle_pct;       // chance in percent that the sender sits out a cycle
   int items_sent;
   int largest_set;
   int quiet_cycles;

   merge_sort_block_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   sorted_set_monitor monitor_inst (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow),
      .fail_count       (fail_count),
      .pending          (pending),
      .sets_closed      (sets_closed),
      .results_checked  (results_checked),
      .overflow_sets    (overflow_sets)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog: any accepted item or result restarts the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no progress for %0d cycles, %0d results still due",
                     QUIET_LIMIT, pending);
            $display("merge_sort_block_unit test failed");
            $finish;
         end
      end
   end

   // one item; idle cycles first, with junk on the data while start is low
   task automatic push_item(input logic signed [DATA_W-1:0] value, input logic closes_set);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start     <= 1'b0;
         req_value <= $urandom;
         req_last  <= 1'($urandom_range(1));
         @(negedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      req_last  <= closes_set;
      // busy is sampled as it stood before the edge
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // half wide random values, the rest small ones for duplicates and the extremes
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2, 3, 4: return $signed(DATA_W'($urandom_range(16))) - 8;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_set(input int set_len);
      for (int k = 0; k < set_len; k++)
         push_item(pick_value(), k == set_len - 1);
      if (set_len > largest_set)
         largest_set = set_len;
   endtask

   initial begin
      // directed sets: a single item, a reversed pair, the extremes with
      // duplicates and alternating bit patterns, equal values, a short mixed pair
      logic signed [DATA_W-1:0] directed_values[$] = '{
         VALUE_MIN,
         VALUE_MAX, VALUE_MIN,
         0, -1, 1, VALUE_MAX, VALUE_MIN, 5, 5, -5, 32'sh5555_5555, 32'shAAAA_AAAA,
         7, 7, 7,
         -3, 2
      };
      int directed_lens[$] = '{1, 2, 10, 3, 2};
      // sender idling per phase; the receiver phases fall away, no back-pressure
      int phase_idle[3]   = '{0, 59, 35};
      // each phase opens with a fixed size: a full buffer, none, an overflow
      int phase_opener[3] = '{MAX_ITEMS, 0, MAX_ITEMS + 2};
      int pos;
      int phase_start;

      reset        = 1'b1;
      start        = 1'b0;
      req_value    = '0;
      req_last     = 1'b0;
      idle_pct     = 0;
      items_sent   = 0;
      largest_set  = 0;
      quiet_cycles = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      pos = 0;
      foreach (directed_lens[s]) begin
         for (int k = 0; k < directed_lens[s]; k++) begin
            push_item(directed_values[pos], k == directed_lens[s] - 1);
            pos++;
         end
      end

      foreach (phase_idle[p]) begin
         idle_pct    = phase_idle[p];
         phase_start = items_sent;
         if (phase_opener[p] > 0)
            send_random_set(phase_opener[p]);
         while (items_sent - phase_start < PHASE_ITEMS) begin
            // now and then a set around the buffer size, else a short one
            if ($urandom_range(24) == 0)
               send_random_set($urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 3));
            else
               send_random_set($urandom_range(1, 12));
         end
      end

      @(negedge clock);
      start <= 1'b0;
      wait (pending == 0);
      // emission ends on the strobe, a short tail catches stray results
      repeat (40) @(posedge clock);

      $display("sent %0d items in %0d sets (largest %0d, %0d with dropped items)",
               items_sent, sets_closed, largest_set, overflow_sets);
      $display("checked %0d sorted results, %0d mismatches", results_checked, fail_count);
      if (fail_count == 0 && pending == 0)
         $display("merge_sort_block_unit test passed");
      else
         $display("merge_sort_block_unit test failed");
      $finish;
   end

endmodule

// ===== merge_sort_block_unit.f =====
hw/rtl/msb_pkg.sv
hw/rtl/msb_ctrl.sv
hw/rtl/msb_dpath.sv
hw/rtl/merge_sort_block_unit.sv
bench/sorted_set_monitor.sv
bench/testbench.sv
